### sv/assert_macros.svh
// Assertion macros used by video_port_and_line_timing.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### sv/vplt_pkg.sv
`default_nettype none

package vplt_pkg;

  localparam int VRAM_DEPTH_DEF     = 16384;
  localparam int REGISTER_COUNT_DEF = 11;
  localparam int LINE_CYCLES_DEF    = 228;
  localparam int ACTIVE_LINES_DEF   = 192;
  localparam int TOTAL_LINES_DEF    = 262;

  // Color RAM depth; the entry index is the address modulo this power of two.
  localparam int PAL_DEPTH = 32;

  localparam logic [2:0] MODE_CTRL = 3'd0;
  localparam logic [2:0] MODE_DWR  = 3'd1;
  localparam logic [2:0] MODE_DRD  = 3'd2;
  localparam logic [2:0] MODE_STAT = 3'd3;
  localparam logic [2:0] MODE_TICK = 3'd4;

  localparam logic [1:0] CODE_VRD  = 2'd0;
  localparam logic [1:0] CODE_VWR  = 2'd1;
  localparam logic [1:0] CODE_REG  = 2'd2;
  localparam logic [1:0] CODE_CRAM = 2'd3;

  localparam int REG_MODE1   = 0;
  localparam int REG_MODE2   = 1;
  localparam int REG_LINECNT = 10;
  localparam int LINE_IE_BIT  = 4;
  localparam int FRAME_IE_BIT = 5;

  localparam logic [7:0] CD_RESET = 8'hFF;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_LINES
  } vplt_state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] bus_byte;
    logic [7:0] elapsed_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        frame_irq_raised;
    logic        line_irq_raised;
    logic        frame_irq_level;
    logic        line_irq_level;
    logic        palette_write_valid;
    logic [4:0]  palette_write_index;
    logic [15:0] palette_write_color;
  } out_item_t;

  function automatic logic [15:0] to_rgb565(logic [7:0] v);
    logic [1:0] r;
    logic [1:0] g;
    logic [1:0] b;
    r = v[1:0];
    g = v[3:2];
    b = v[5:4];
    return {r, r, r[1], g, g, g, b, b, b[1]};
  endfunction

endpackage

`default_nettype wire

### sv/video_port_and_line_timing.sv
// Channel | Ports                              | Item
// --------+------------------------------------+---------------------------------------
// input   | in_valid, in_ready, in_item        | mode, bus_byte, elapsed_cycles
// result  | out_valid, out_ready, out_item     | read value, IRQ flags, color RAM write
//
// After reset the video RAM is cleared to zero; no item is taken until the clear is done.
// A new item can enter every cycle unless the skid register is full or a tick is still on its lines.
// A tick works through every line it completes, one after another, and then gives a single result.
// An output register and a skid register let one item enter while a result waits.
// The video RAM has one port; a read lands in a data register in the cycle after it is issued.
`default_nettype none
`include "assert_macros.svh"

module video_port_and_line_timing
  import vplt_pkg::*;
#(
  parameter int VRAM_DEPTH     = VRAM_DEPTH_DEF,
  parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
  parameter int LINE_CYCLES    = LINE_CYCLES_DEF,
  parameter int ACTIVE_LINES   = ACTIVE_LINES_DEF,
  parameter int TOTAL_LINES    = TOTAL_LINES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  localparam int VA_W = $clog2(VRAM_DEPTH);
  localparam int RI_W = $clog2(REGISTER_COUNT);

  function automatic logic [VA_W-1:0] vram_index(logic [13:0] a);
    logic [18:0] r;
    r = {5'd0, a};
    for (int k = 4; k >= 0; k--) begin
      if (r >= (19'(VRAM_DEPTH) << k)) begin
        r = r - (19'(VRAM_DEPTH) << k);
      end
    end
    return r[VA_W-1:0];
  endfunction

  logic [7:0] vram_mem [VRAM_DEPTH];
  logic [7:0] vram_q_r;
  logic            mem_we;
  logic            mem_re;
  logic [VA_W-1:0] mem_addr;
  logic [7:0]      mem_wdata;

  vplt_state_t st_r, st_nxt;
  logic [VA_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [7:0]  regs_r [REGISTER_COUNT];
  logic        reg_we;
  logic [RI_W-1:0] reg_wi;

  logic [13:0] addr_r, addr_nxt;
  logic [1:0]  code_r, code_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  prefetch_r, prefetch_nxt;
  logic        pf_mem_r, pf_mem_nxt;
  logic        fstat_r, fstat_nxt;
  logic        fflag_r, fflag_nxt;
  logic        lflag_r, lflag_nxt;
  logic [7:0]  cd_r, cd_nxt;
  logic [8:0]  line_r, line_nxt;
  logic [8:0]  acc_r, acc_nxt;
  logic        fr_r, fr_nxt;
  logic        lr_r, lr_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  out_item_t   skid_r, skid_nxt;

  logic        accept;
  logic        tick_go;
  logic        tick_done;
  logic [8:0]  cur_acc;
  logic [8:0]  line_inc;
  logic        push;
  out_item_t   res;
  logic        pop;
  logic [13:0] ctrl_addr;
  logic [7:0]  eff_pf;

  assign accept = in_valid && in_ready;
  assign eff_pf = pf_mem_r ? vram_q_r : prefetch_r;
  assign ctrl_addr = {in_item.bus_byte[5:0], held_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (clr_cnt_r == VA_W'(VRAM_DEPTH - 1)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tick_go && !tick_done) begin
          st_nxt = ST_LINES;
        end
      end
      ST_LINES: begin
        if (tick_done) begin
          st_nxt = ST_RUN;
        end
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = (st_r == ST_RUN) && !skid_valid_r;
    clr_cnt_nxt = (st_r == ST_CLEAR) ? clr_cnt_r + VA_W'(1) : clr_cnt_r;
  end

  always_comb begin
    addr_nxt     = addr_r;
    code_nxt     = code_r;
    pend_nxt     = pend_r;
    held_nxt     = held_r;
    prefetch_nxt = prefetch_r;
    pf_mem_nxt   = pf_mem_r;
    fstat_nxt    = fstat_r;
    fflag_nxt    = fflag_r;
    lflag_nxt    = lflag_r;
    cd_nxt       = cd_r;
    line_nxt     = line_r;
    acc_nxt      = acc_r;
    fr_nxt       = fr_r;
    lr_nxt       = lr_r;
    reg_we       = 1'b0;
    reg_wi       = in_item.bus_byte[RI_W-1:0];
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = vram_index(addr_r);
    mem_wdata    = in_item.bus_byte;
    res          = '0;
    line_inc     = line_r + 9'd1;

    if (st_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r;
      mem_wdata = '0;
    end

    tick_go = (accept && (in_item.mode == MODE_TICK)) || (st_r == ST_LINES);
    cur_acc = (st_r == ST_LINES) ? acc_r : acc_r + {1'b0, in_item.elapsed_cycles};
    if (st_r != ST_LINES) begin
      fr_nxt = 1'b0;
      lr_nxt = 1'b0;
    end

    if (tick_go && (cur_acc >= 9'(LINE_CYCLES))) begin
      acc_nxt = cur_acc - 9'(LINE_CYCLES);
      if (line_r < 9'(ACTIVE_LINES)) begin
        if (cd_r == 8'd0) begin
          if (regs_r[REG_MODE1][LINE_IE_BIT]) begin
            lflag_nxt = 1'b1;
            lr_nxt    = 1'b1;
          end
          cd_nxt = regs_r[REG_LINECNT];
        end else begin
          cd_nxt = cd_r - 8'd1;
        end
      end else if (line_r == 9'(ACTIVE_LINES)) begin
        cd_nxt    = regs_r[REG_LINECNT];
        fstat_nxt = 1'b1;
        if (regs_r[REG_MODE2][FRAME_IE_BIT]) begin
          fflag_nxt = 1'b1;
          fr_nxt    = 1'b1;
        end
      end
      line_nxt = (line_inc >= 9'(TOTAL_LINES)) ? 9'd0 : line_inc;
    end else if (tick_go) begin
      acc_nxt = cur_acc;
    end
    tick_done = tick_go && (acc_nxt < 9'(LINE_CYCLES));

    if (accept) begin
      unique case (in_item.mode)
        MODE_CTRL: begin
          if (!pend_r) begin
            held_nxt = in_item.bus_byte;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            code_nxt = in_item.bus_byte[7:6];
            if (in_item.bus_byte[7:6] == CODE_REG) begin
              reg_we = 5'(in_item.bus_byte[3:0]) < 5'(REGISTER_COUNT);
            end else begin
              addr_nxt = ctrl_addr;
              if (in_item.bus_byte[7:6] == CODE_VRD) begin
                mem_re     = 1'b1;
                mem_addr   = vram_index(ctrl_addr);
                pf_mem_nxt = 1'b1;
                addr_nxt   = ctrl_addr + 14'd1;
              end
            end
          end
        end
        MODE_DWR: begin
          pend_nxt = 1'b0;
          if (code_r == CODE_CRAM) begin
            res.palette_write_valid = 1'b1;
            res.palette_write_index = 5'(addr_r & 14'(PAL_DEPTH - 1));
            res.palette_write_color = to_rgb565(in_item.bus_byte);
          end else begin
            mem_we = 1'b1;
          end
          prefetch_nxt = in_item.bus_byte;
          pf_mem_nxt   = 1'b0;
          addr_nxt     = addr_r + 14'd1;
        end
        MODE_DRD: begin
          res.read_value = eff_pf;
          mem_re     = 1'b1;
          pf_mem_nxt = 1'b1;
          addr_nxt   = addr_r + 14'd1;
          pend_nxt   = 1'b0;
        end
        MODE_STAT: begin
          res.read_value = {fstat_r, 7'd0};
          fstat_nxt = 1'b0;
          fflag_nxt = 1'b0;
          lflag_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end

    res.frame_irq_raised = tick_go && fr_nxt;
    res.line_irq_raised  = tick_go && lr_nxt;
    res.frame_irq_level  = fflag_nxt;
    res.line_irq_level   = lflag_nxt;
    push = (accept && (in_item.mode != MODE_TICK)) || tick_done;
  end

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end else if (pop) begin
      out_valid_nxt  = skid_valid_r;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      vram_q_r <= vram_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_r[i] <= '0;
      end
    end else if (reg_we) begin
      regs_r[reg_wi] <= held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_cnt_r    <= '0;
      addr_r       <= '0;
      code_r       <= CODE_VRD;
      pend_r       <= 1'b0;
      held_r       <= '0;
      prefetch_r   <= '0;
      pf_mem_r     <= 1'b0;
      fstat_r      <= 1'b0;
      fflag_r      <= 1'b0;
      lflag_r      <= 1'b0;
      cd_r         <= CD_RESET;
      line_r       <= '0;
      acc_r        <= '0;
      fr_r         <= 1'b0;
      lr_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      addr_r       <= addr_nxt;
      code_r       <= code_nxt;
      pend_r       <= pend_nxt;
      held_r       <= held_nxt;
      prefetch_r   <= prefetch_nxt;
      pf_mem_r     <= pf_mem_nxt;
      fstat_r      <= fstat_nxt;
      fflag_r      <= fflag_nxt;
      lflag_r      <= lflag_nxt;
      cd_r         <= cd_nxt;
      line_r       <= line_nxt;
      acc_r        <= acc_nxt;
      fr_r         <= fr_nxt;
      lr_r         <= lr_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  `ASSERT_NEVER(a_skid_alone, clk, rst_n, skid_valid_r && !out_valid_r, "skid item without output item")
  `ASSERT_HOLDS(a_lines_owed, clk, rst_n, (st_r == ST_LINES) |-> (acc_r >= 9'(LINE_CYCLES)), "line state without a full line")
  `ASSERT_HOLDS(a_acc_below, clk, rst_n, (st_r != ST_LINES) |-> (acc_r < 9'(LINE_CYCLES)), "cycle count left a full line")
  `ASSERT_NEVER(a_line_range, clk, rst_n, line_r >= 9'(TOTAL_LINES), "line counter beyond frame")

endmodule

`default_nettype wire
